/* rtl/ssfc_pkg.sv */
// Package for the sorted symbol frequency counter.
// Holds request codes, status codes, default sizes and the queue entry type.
package ssfc_pkg;

  localparam int unsigned SsfcCapacity   = 64;
  localparam int unsigned SsfcKeyBytes   = 4;
  localparam int unsigned SsfcCountWidth = 32;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned TotalW = 7;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_GET  = 2'd1,
    REQ_DUMP = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DUMP,
    BK_WAIT
  } back_state_e;

  // Classified request handed from front to back
  typedef struct packed {
    req_e            req;
    logic [KeyW-1:0] key;
  } cmd_t;

  // Normalise a key: cut to the given bytes, clear everything from the first zero byte
  function automatic logic [KeyW-1:0] norm_key(input logic [KeyW-1:0] k,
                                               input int unsigned nbytes);
    logic [KeyW-1:0] res;
    logic            stop;
    res  = '0;
    stop = 1'b0;
    for (int b = 3; b >= 0; b--) begin
      if (b < int'(nbytes)) begin
        if (k[b*8 +: 8] == 8'd0) stop = 1'b1;
        if (!stop) res[b*8 +: 8] = k[b*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage

/* rtl/ssfc_front.sv */
// Front end: accepts requests, normalises keys, drops unused codes, feeds the queue.
// Depends on ssfc_pkg.
module ssfc_front import ssfc_pkg::*; #(
  parameter int unsigned KEY_BYTES = SsfcKeyBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic [KeyW-1:0] s_key_i,
  input  logic [1:0]      s_req_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output cmd_t            q_cmd_o
);

  // Two-entry queue
  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign s_tready_o = (cnt_q != 2'd2);
  assign push       = s_tvalid_i && s_tready_o && (s_req_i != REQ_NONE);
  assign pop        = q_valid_o && q_ready_i;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rd_q];

  // Store classified request
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].req <= req_e'(s_req_i);
      mem_q[wr_q].key <= norm_key(s_key_i, KEY_BYTES);
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/ssfc_back.sv */
// Back end: sorted cell row with parallel compare and shift, dump sequencer, output register.
// Depends on ssfc_pkg.
module ssfc_back import ssfc_pkg::*; #(
  parameter int unsigned CAPACITY    = SsfcCapacity,
  parameter int unsigned COUNT_WIDTH = SsfcCountWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  cmd_t              q_cmd_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [1:0]        m_status_o,
  output logic [KeyW-1:0]   m_key_o,
  output logic [CountW-1:0] m_count_o,
  output logic [TotalW-1:0] m_total_o,
  output logic              m_last_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned OccW = $clog2(CAPACITY + 1);
  localparam logic [CountW-1:0] CountMax = CountW'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [KeyW-1:0]   keys_q   [CAPACITY];
  logic [CountW-1:0] counts_q [CAPACITY];
  logic [OccW-1:0]   occ_q;

  back_state_e st_q, st_d;
  logic [OccW-1:0] dptr_q, dptr_d;

  logic              ovalid_q, ovalid_d;
  logic [1:0]        ostat_q, ostat_d;
  logic [KeyW-1:0]   okey_q, okey_d;
  logic [CountW-1:0] ocnt_q, ocnt_d;
  logic              olast_q, olast_d;

  // Per-cell compare against the request key
  logic [CAPACITY-1:0] lt, eq;
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (OccW'(i) < occ_q) && (keys_q[i] < q_cmd_i.key);
      eq[i] = (OccW'(i) < occ_q) && (keys_q[i] == q_cmd_i.key);
    end
  end

  logic              hit;
  logic [CountW-1:0] hit_cnt;
  always_comb begin
    hit     = |eq;
    hit_cnt = '0;
    for (int i = 0; i < CAPACITY; i++) if (eq[i]) hit_cnt = counts_q[i];
  end

  logic full, out_free, take, do_ins, do_inc;
  assign full     = (occ_q == OccW'(CAPACITY));
  assign out_free = !ovalid_q || m_tready_i;

  // Sequence requests and dumps
  always_comb begin
    st_d     = st_q;
    dptr_d   = dptr_q;
    ovalid_d = ovalid_q && !m_tready_i;
    ostat_d  = ostat_q;
    okey_d   = okey_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;
    take     = 1'b0;
    do_ins   = 1'b0;
    do_inc   = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (q_valid_i && out_free) begin
          take     = 1'b1;
          ovalid_d = 1'b1;
          okey_d   = q_cmd_i.key;
          olast_d  = 1'b1;
          ostat_d  = ST_OK;
          unique case (q_cmd_i.req)
            REQ_ADD: begin
              if (hit) begin
                do_inc = 1'b1;
                ocnt_d = (hit_cnt == CountMax) ? hit_cnt : hit_cnt + 1'b1;
              end else if (full) begin
                ostat_d = ST_FULL;
                ocnt_d  = '0;
              end else begin
                do_ins = 1'b1;
                ocnt_d = CountW'(1);
              end
              st_d = BK_WAIT;
            end
            REQ_GET: begin
              ocnt_d = hit ? hit_cnt : '0;
              st_d   = BK_WAIT;
            end
            default: begin
              if (occ_q == '0) begin
                ostat_d = ST_EMPTY;
                okey_d  = '0;
                ocnt_d  = '0;
                st_d    = BK_WAIT;
              end else begin
                ovalid_d = 1'b0;
                olast_d  = 1'b0;
                dptr_d   = occ_q;
                st_d     = BK_DUMP;
              end
            end
          endcase
        end
      end
      BK_DUMP: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ostat_d  = ST_OK;
          okey_d   = keys_q[dptr_q[IdxW-1:0] - 1'b1];
          ocnt_d   = counts_q[dptr_q[IdxW-1:0] - 1'b1];
          olast_d  = (dptr_q == OccW'(1));
          dptr_d   = dptr_q - 1'b1;
          if (dptr_q == OccW'(1)) st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  assign q_ready_o = take;

  // Compare-and-shift update of the cell row
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_inc && eq[i]) begin
        counts_q[i] <= ocnt_d;
      end else if (do_ins && !lt[i] && (OccW'(i) <= occ_q)) begin
        if (i == 0 || lt[(i == 0) ? 0 : i-1]) begin
          keys_q[i]   <= q_cmd_i.key;
          counts_q[i] <= CountW'(1);
        end else begin
          keys_q[i]   <= keys_q[(i == 0) ? 0 : i-1];
          counts_q[i] <= counts_q[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    ostat_q <= ostat_d;
    okey_q  <= okey_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= BK_IDLE;
      dptr_q   <= '0;
      occ_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= (st_d == BK_WAIT) ? BK_IDLE : st_d;
      dptr_q   <= dptr_d;
      ovalid_q <= ovalid_d;
      if (do_ins) occ_q <= occ_q + 1'b1;
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_status_o = ostat_q;
  assign m_key_o    = okey_q;
  assign m_count_o  = ocnt_q;
  assign m_total_o  = TotalW'(occ_q);
  assign m_last_o   = olast_q;

endmodule

/* rtl/sorted_symbol_frequency_counter_unit.sv */
// Top level of the sorted symbol frequency counter.
// Depends on ssfc_pkg, ssfc_front and ssfc_back.
//
// Slave channel takes requests: tuser is req_type (add, get, dump), tdata the key.
// Master channel returns results: tdata holds status, key, count and entry total,
// tlast marks the final result of a request.
// Add and get: one result, through the front queue and the output register; the
// front queue takes a new request every cycle while it has room, and the back end
// handles one add or get per cycle while the output register is free, through a
// parallel compare-and-shift over all cells, so with a ready receiver a stream
// sustains one request per cycle. Dump: the back end takes it into the dump state,
// then gives one result per cycle from the highest key down, occupancy results in
// all, paced by the output register; an empty table gives one result with status 2.
// Request type 3 is dropped with no result.
// Reset empties the table and the queue; stored keys are not cleared.
// A stalled receiver holds the output register; the back end then waits and
// the two-entry front queue fills before the slave tready drops.
module sorted_symbol_frequency_counter_unit import ssfc_pkg::*; #(
  parameter int unsigned CAPACITY    = SsfcCapacity,
  parameter int unsigned KEY_BYTES   = SsfcKeyBytes,
  parameter int unsigned COUNT_WIDTH = SsfcCountWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,  // key[31:0]
  input  logic [1:0]   s_axis_tuser_i,  // req_type[1:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [79:0]  m_axis_tdata_o,  // status[1:0], out_key[33:2], out_count[65:34],
                                        // entry_total[72:66], zero[79:73]
  output logic         m_axis_tlast_o
);

  logic q_valid, q_ready;
  cmd_t q_cmd;
  logic [1:0]        st;
  logic [KeyW-1:0]   ok;
  logic [CountW-1:0] oc;
  logic [TotalW-1:0] ot;

  ssfc_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid_i), .s_tready_o(s_axis_tready_o),
    .s_key_i(s_axis_tdata_i), .s_req_i(s_axis_tuser_i),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  ssfc_back #(.CAPACITY(CAPACITY), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .m_tvalid_o(m_axis_tvalid_o), .m_tready_i(m_axis_tready_i),
    .m_status_o(st), .m_key_o(ok), .m_count_o(oc), .m_total_o(ot),
    .m_last_o(m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, ot, oc, ok, st};

endmodule

/* rtl/ssfc_checker.sv */
// Port-level checker for the sorted symbol frequency counter, bound to the top level.
// Depends on ssfc_pkg.
module ssfc_port_checker import ssfc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_i,
  input logic        m_axis_tlast_i
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed under stall");

  // Entry total never above 64
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[72:66] <= 7'd64)
    else $error("entry total out of range");

  // Empty dump and full drop always end their request, with a zero count
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (m_axis_tdata_i[1:0] == ST_EMPTY || m_axis_tdata_i[1:0] == ST_FULL)
    |-> m_axis_tlast_i && m_axis_tdata_i[65:34] == 32'd0)
    else $error("bad special result");

  // Empty dump only with no entries
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[1:0] == ST_EMPTY |-> m_axis_tdata_i[72:66] == 7'd0)
    else $error("empty dump with entries");

endmodule

bind sorted_symbol_frequency_counter_unit ssfc_port_checker u_ssfc_port_checker (
  .clk_i, .rst_ni,
  .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tlast_i(m_axis_tlast_o)
);

/* bench/ssfc_checker.sv */
// Checker for the sorted symbol frequency counter: watches both streams,
// predicts results from accepted requests and compares them. Depends on ssfc_pkg.
`timescale 1ns / 1ps
module ssfc_checker import ssfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,   // key[31:0]
  input  logic [1:0]  s_axis_tuser_i,   // req_type[1:0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [79:0] m_axis_tdata_i,   // status, out_key, out_count, entry_total
  input  logic        m_axis_tlast_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    status_e     status;
    logic [31:0] key;
    logic [31:0] count;
    logic [6:0]  total;
    logic        last;
  } result_t;

  logic [31:0] hist_keys [SsfcCapacity];
  logic [31:0] hist_counts [SsfcCapacity];
  int          hist_used;
  result_t     expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic [31:0] trim_symbol(logic [31:0] k);
    logic [31:0] r;
    r = '0;
    for (int b = 3; b >= 0; b--) begin
      if (k[b*8 +: 8] == 8'd0) break;
      r[b*8 +: 8] = k[b*8 +: 8];
    end
    return r;
  endfunction

  // Update the histogram with one request and queue its results
  task automatic tally_request(req_e req, logic [31:0] raw);
    logic [31:0] k;
    int          p;
    logic [31:0] c;
    k = trim_symbol(raw);
    p = 0;
    while (p < hist_used && hist_keys[p] < k) p++;
    case (req)
      REQ_ADD: begin
        if (p < hist_used && hist_keys[p] == k) begin
          if (hist_counts[p] != 32'hFFFF_FFFF) hist_counts[p]++;
          expected_q.push_back('{ST_OK, k, hist_counts[p], 7'(hist_used), 1'b1});
        end else if (hist_used >= SsfcCapacity) begin
          expected_q.push_back('{ST_FULL, k, 32'd0, 7'(hist_used), 1'b1});
        end else begin
          for (int i = hist_used; i > p; i--) begin
            hist_keys[i]   = hist_keys[i-1];
            hist_counts[i] = hist_counts[i-1];
          end
          hist_keys[p]   = k;
          hist_counts[p] = 32'd1;
          hist_used++;
          expected_q.push_back('{ST_OK, k, 32'd1, 7'(hist_used), 1'b1});
        end
      end
      REQ_GET: begin
        c = (p < hist_used && hist_keys[p] == k) ? hist_counts[p] : 32'd0;
        expected_q.push_back('{ST_OK, k, c, 7'(hist_used), 1'b1});
      end
      REQ_DUMP: begin
        if (hist_used == 0)
          expected_q.push_back('{ST_EMPTY, 32'd0, 32'd0, 7'd0, 1'b1});
        for (int i = hist_used; i > 0; i--)
          expected_q.push_back('{ST_OK, hist_keys[i-1], hist_counts[i-1],
                                 7'(hist_used), 1'(i == 1)});
      end
      default: ;
    endcase
  endtask

  // Predict on requests, compare on results
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      hist_used    = 0;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{status_e'(m_axis_tdata_i[1:0]), m_axis_tdata_i[33:2],
                m_axis_tdata_i[65:34], m_axis_tdata_i[72:66], m_axis_tlast_i};
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", got);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_axis_tdata_i[79:73] !== 7'd0) begin
            if (fail_count_o < 10)
              $display("mismatch: expected st=%0d key=%h cnt=%0d tot=%0d last=%b, got st=%0d key=%h cnt=%0d tot=%0d last=%b pad=%h",
                       want.status, want.key, want.count, want.total, want.last,
                       got.status, got.key, got.count, got.total, got.last,
                       m_axis_tdata_i[79:73]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        tally_request(req_e'(s_axis_tuser_i), s_axis_tdata_i);
    end
  end

endmodule

/* bench/testbench.sv */
// Top of the testbench: clock, reset, request stimulus and verdict.
// Depends on ssfc_pkg, ssfc_checker and sorted_symbol_frequency_counter_unit.
`timescale 1ns / 1ps
module testbench import ssfc_pkg::*;;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid_i, s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;  // key[31:0]
  logic [1:0]  s_axis_tuser_i;  // req_type[1:0]
  logic        m_axis_tvalid_o, m_axis_tready_i, m_axis_tlast_o;
  logic [79:0] m_axis_tdata_o;  // status, out_key, out_count, entry_total
  int          fail_count, pending;
  int          send_idle_pct, recv_idle_pct;
  logic [31:0] key_pool [16];

  sorted_symbol_frequency_counter_unit uut (.*);

  ssfc_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .s_axis_tuser_i, .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tlast_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // Stall the receiver at random
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one request, with a random gap first, and hold it until taken
  task automatic send_request(req_e req, logic [31:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= key;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    k = key_pool[$urandom_range(15)];
    case ($urandom_range(3))
      0: k = $urandom;
      1: k[7:0] = 8'($urandom);
      default: ;
    endcase
    return k;
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55)      send_request(REQ_ADD, pick_key());
      else if (r < 85) send_request(REQ_GET, pick_key());
      else if (r < 95) send_request(REQ_DUMP, $urandom);
      else             send_request(REQ_NONE, $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_ADD;
    send_idle_pct = 7;
    recv_idle_pct = 71;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h4100_0000;
    key_pool[1] = 32'h4142_0000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty dump, extremes, zero-byte trimming, ignored type
    send_request(REQ_DUMP, 32'h0);
    send_request(REQ_GET, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'h0000_0000);
    send_request(REQ_ADD, 32'h00FF_FFFF);
    send_request(REQ_ADD, 32'h4100_4243);
    send_request(REQ_ADD, 32'h4142_0043);
    send_request(REQ_GET, 32'h4100_0000);
    send_request(REQ_GET, 32'h1234_5678);
    send_request(REQ_NONE, 32'hAAAA_5555);
    send_request(REQ_DUMP, 32'hFFFF_FFFF);
    // Fill the table to overflow, then dump it
    for (int i = 0; i < 66; i++) send_request(REQ_ADD, {8'h80 + 8'(i), 24'h010101});
    send_request(REQ_ADD, 32'h7F00_0000);
    send_request(REQ_DUMP, 32'h0);

    random_phase(90);
    send_idle_pct = 71;
    recv_idle_pct = 7;
    random_phase(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(90);
    s_axis_tvalid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("sorted_symbol_frequency_counter_unit verification clean");
    else
      $display("sorted_symbol_frequency_counter_unit verification failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("sorted_symbol_frequency_counter_unit verification failed");
    $finish;
  end

endmodule
